// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: geometry constants, header
// entry type and status codes. No dependencies.
`default_nettype none
package ffha_pkg;
  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned WordBytes   = 8;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned HeapPages   = 16;
  localparam int unsigned MinSplit    = 24;
  localparam int unsigned Depth       = HeapPages * PageBytes / WordBytes;
  localparam int unsigned AW          = $clog2(Depth);
  localparam int unsigned OW          = AW + $clog2(WordBytes) + 1; // byte offsets incl. end
  localparam int unsigned PW          = 5;
  localparam int unsigned PageSh      = $clog2(PageBytes);
  localparam int unsigned WordSh      = $clog2(WordBytes);

  typedef struct packed {
    logic        is_free;
    logic [16:0] size;
  } hdr_t;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StOom    = 2'd1,
    StDouble = 2'd2,
    StIgnore = 2'd3
  } status_e;
endpackage
`default_nettype wire

// ===== rtl/ffha_if.sv =====
// Valid/ready channel interfaces for the allocator's request and result.
// Depends on nothing.
`default_nettype none
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] request_bytes;
  logic [15:0] block_address;
  modport source (output valid, mode, request_bytes, block_address, input ready);
  modport sink (input valid, mode, request_bytes, block_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] address;
  logic [15:0] block_size;
  logic [4:0]  pages_used;
  modport source (output valid, status, address, block_size, pages_used, input ready);
  modport sink (input valid, status, address, block_size, pages_used, output ready);
endinterface
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: sequencer walking the header
// store. Uses ffha_pkg, ffha_if and ffha_ram.
//
//  channel   dir  signals
//  req       in   valid ready mode request_bytes block_address
//  rsp       out  valid ready status address block_size pages_used
//  cfg       in   cfg_we_i cfg_data_i (max_pages)
//
// One transaction at a time. Each header visited passes through a read
// state and a check state, as the RAM read is registered. No clearing
// pass after reset. The result sits in an output register until taken;
// the next request is accepted only after that.
`default_nettype none
module first_fit_heap_allocator_core import ffha_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_data_i,
  ffha_req_if.sink        req,
  ffha_rsp_if.source      rsp
);
  typedef enum logic [3:0] {
    SIdle, SRd, SChk, SGrow, SSplit, SFNext, SFNextChk, SFPrev, SFPrevChk, SFWrite, SDone
  } state_e;

  state_e      state_q;
  logic [4:0]  maxp_q, pages_q;
  logic        mode_q;
  logic [16:0] real_q, size_q, msize_q;
  logic [OW-1:0] off_q, prev_q, tgt_q, start_q;
  logic        has_prev_q;
  logic [1:0]  st_q;
  logic [15:0] oaddr_q, osize_q;
  logic        ovalid_q;

  logic          we;
  logic [OW-1:0] raddr;
  hdr_t          wdata, rdata;

  ffha_ram u_ram (.clk_i, .we_i(we), .addr_i(raddr[WordSh +: AW]), .wdata_i(wdata),
                  .rdata_o(rdata));

  logic [OW-1:0] end_w, step_w;
  logic [4:0]    lim_w, pginc_w;
  logic [17:0]   need_w;
  assign end_w  = OW'({pages_q, {PageSh{1'b0}}});
  assign step_w = off_q + OW'(HeaderBytes) + OW'(rdata.size);
  assign lim_w  = (maxp_q > 5'(HeapPages)) ? 5'(HeapPages) : maxp_q;
  assign need_w = 18'(real_q) + 18'(HeaderBytes) + 18'(PageBytes - 1);
  assign pginc_w = 5'(need_w >> PageSh);

  // combinational RAM port control
  always_comb begin
    we = 1'b0; raddr = off_q; wdata = '0;
    unique case (state_q)
      SGrow: begin
        // write the new region only when the growth fits the limit
        we = (6'(pages_q) + 6'(pginc_w) <= 6'(lim_w)); raddr = end_w;
        wdata = '{1'b1, 17'(({12'd0, pginc_w} << PageSh) - HeaderBytes)};
      end
      SSplit: begin
        we = 1'b1;
        if (size_q - real_q >= 17'(HeaderBytes + MinSplit)) begin
          raddr = off_q; wdata = '{1'b0, real_q};
        end else begin
          raddr = off_q; wdata = '{1'b0, size_q};
        end
      end
      SDone: begin
        // second half of a split: write the remainder block
        we = (mode_q == 1'b0) && (st_q == StOk) && (size_q - real_q >= 17'(HeaderBytes + MinSplit));
        raddr = off_q + OW'(HeaderBytes) + OW'(real_q);
        wdata = '{1'b1, 17'(size_q - real_q - 17'(HeaderBytes))};
      end
      SFNext: raddr = tgt_q + OW'(HeaderBytes) + OW'(size_q);
      SFPrev: raddr = prev_q;
      SFWrite: begin
        we = 1'b1; raddr = start_q; wdata = '{1'b1, msize_q};
      end
      default: raddr = off_q;
    endcase
  end

  assign req.ready      = (state_q == SIdle) && !ovalid_q;
  assign rsp.valid      = ovalid_q;
  assign rsp.status     = st_q;
  assign rsp.address    = oaddr_q;
  assign rsp.block_size = osize_q;
  assign rsp.pages_used = pages_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; maxp_q <= 5'd16; pages_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) maxp_q <= cfg_data_i;
      if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (req.valid && req.ready) begin
          mode_q <= req.mode;
          real_q <= (17'(req.request_bytes) + 17'(WordBytes - 1)) & ~17'(WordBytes - 1);
          off_q <= '0; has_prev_q <= 1'b0;
          tgt_q <= OW'(req.block_address) - OW'(HeaderBytes);
          oaddr_q <= '0; osize_q <= '0; st_q <= StOk;
          if (req.mode && req.block_address < 16'(HeaderBytes)) begin
            st_q <= StIgnore; state_q <= SDone;
          end else state_q <= SRd;
        end
        SRd: begin
          if (off_q >= end_w) state_q <= mode_q ? SDone : SGrow;
          else if (mode_q && off_q > tgt_q) state_q <= SDone;
          else state_q <= SChk;
          if (mode_q && (off_q >= end_w || off_q > tgt_q)) st_q <= StIgnore;
        end
        SChk: begin
          if (!mode_q) begin
            if (rdata.is_free && rdata.size >= real_q) begin
              size_q <= rdata.size; state_q <= SSplit;
            end else begin
              off_q <= step_w; state_q <= SRd;
            end
          end else if (off_q == tgt_q) begin
            size_q <= rdata.size; msize_q <= rdata.size;
            start_q <= tgt_q;
            if (rdata.is_free) begin
              st_q <= StDouble; state_q <= SDone;
            end else state_q <= SFNext;
          end else begin
            prev_q <= off_q; has_prev_q <= 1'b1; off_q <= step_w; state_q <= SRd;
          end
        end
        SGrow: begin
          if (6'(pages_q) + 6'(pginc_w) > 6'(lim_w)) begin
            st_q <= StOom; state_q <= SDone;
          end else begin
            off_q <= end_w;
            size_q <= 17'(({12'd0, pginc_w} << PageSh) - HeaderBytes);
            pages_q <= pages_q + pginc_w;
            state_q <= SSplit;
          end
        end
        SSplit: begin
          oaddr_q <= 16'(off_q + OW'(HeaderBytes));
          osize_q <= (size_q - real_q >= 17'(HeaderBytes + MinSplit)) ? 16'(real_q)
                                                                      : 16'(size_q);
          state_q <= SDone;
        end
        SFNext: state_q <= SFNextChk;
        SFNextChk: begin
          if ((tgt_q + OW'(HeaderBytes) + OW'(size_q)) < end_w && rdata.is_free)
            msize_q <= msize_q + 17'(HeaderBytes) + rdata.size;
          state_q <= has_prev_q ? SFPrev : SFWrite;
        end
        SFPrev: state_q <= SFPrevChk;
        SFPrevChk: begin
          if (rdata.is_free) begin
            start_q <= prev_q;
            msize_q <= msize_q + rdata.size + 17'(HeaderBytes);
          end
          state_q <= SFWrite;
        end
        SFWrite: begin
          osize_q <= 16'(size_q);
          if (start_q == '0 && (OW'(msize_q) + OW'(HeaderBytes)) == end_w) pages_q <= '0;
          state_q <= SDone;
        end
        SDone: begin
          ovalid_q <= 1'b1; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q |-> state_q == SIdle)
    else $error("result valid while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pages_q <= 5'(HeapPages))
    else $error("page count over heap size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && st_q != StOk) |-> osize_q == '0)
    else $error("size reported on failure");
endmodule
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
// Header store: one synchronous single-port RAM, registered read.
// Uses ffha_pkg.
`default_nettype none
module ffha_ram import ffha_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire hdr_t          wdata_i,
  output hdr_t               rdata_o
);
  hdr_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire
